// ----- sv/u2j_pkg.sv -----
// ----------------------------------------------------------------------------
// u2j_pkg
// Shared types, codes and helpers of the utf-8 to ascii json string escaper.
// ----------------------------------------------------------------------------
package u2j_pkg;

  // controller phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_OPEN  = 6'b000010,
    PH_PRE   = 6'b000100,
    PH_TAIL  = 6'b001000,
    PH_POST  = 6'b010000,
    PH_CLOSE = 6'b100000
  } phase_e;

  // what the byte itself turns into
  typedef enum logic [2:0] {
    TAIL_NONE = 3'd0,
    TAIL_CHAR = 3'd1,
    TAIL_ESC  = 3'd2,
    TAIL_U4   = 3'd3,
    TAIL_PAIR = 3'd4
  } tail_e;

  typedef struct packed {
    logic       open;
    logic [1:0] pre_cnt;
    logic [3:0] tail_len;
    logic [1:0] post_cnt;
    logic       close;
  } plan_info_t;

  typedef struct packed {
    plan_info_t nxt;
    plan_info_t cur;
    logic       out_free;
  } u2j_status_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       last;
    phase_e     phase;
    logic [3:0] pos;
  } u2j_cmd_t;

  localparam logic [6:0]  CharQuote  = 7'h22;
  localparam logic [6:0]  CharBslash = 7'h5c;
  localparam logic [6:0]  CharU      = 7'h75;
  localparam logic [15:0] CodeRepl   = 16'hfffd;

  localparam logic [3:0] TailLenChar = 4'd1;
  localparam logic [3:0] TailLenEsc  = 4'd2;
  localparam logic [3:0] TailLenU4   = 4'd6;
  localparam logic [3:0] TailLenPair = 4'd12;

  localparam logic [3:0] U4LastPos = 4'd5;

  // lowercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) begin
      r = 7'h30 + {3'b000, n};
    end else begin
      r = 7'h57 + {3'b000, n};
    end
    return r;
  endfunction

endpackage

// ----- sv/u2j_in_if.sv -----
// ----------------------------------------------------------------------------
// u2j_in_if
// Input channel: one string byte per word with start and end marks.
// ----------------------------------------------------------------------------
interface u2j_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       string_start;
  logic       string_end;

  modport source (
    output valid, data_byte, has_byte, string_start, string_end,
    input  ready
  );
  modport sink (
    input  valid, data_byte, has_byte, string_start, string_end,
    output ready
  );
endinterface

// ----- sv/u2j_out_if.sv -----
// ----------------------------------------------------------------------------
// u2j_out_if
// Output channel: one escaped ascii character per word.
// ----------------------------------------------------------------------------
interface u2j_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (
    output valid, out_char, run_last,
    input  ready
  );
  modport sink (
    input  valid, out_char, run_last,
    output ready
  );
endinterface

// ----- sv/u2j_dp.sv -----
// ----------------------------------------------------------------------------
// u2j_dp
// Datapath: utf-8 sequence buffer, per-word output plan and character mux.
// ----------------------------------------------------------------------------
module u2j_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic                  has_byte_i,
  input  logic                  string_start_i,
  input  logic                  string_end_i,
  input  u2j_pkg::u2j_cmd_t     cmd_i,
  output u2j_pkg::u2j_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [6:0]            out_char_o,
  output logic                  run_last_o
);

  // sequence buffer
  logic [7:0] pend_q [3];
  logic [1:0] pcnt_q, pcnt_d;
  logic [2:0] elen_q, elen_d;

  // plan of the word in flight
  logic            open_q, open_d;
  logic [1:0]      pre_q, pre_d;
  logic [1:0]      post_q, post_d;
  logic            close_q, close_d;
  u2j_pkg::tail_e  tail_q, tail_d;
  logic [6:0]      tchar_q, tchar_d;
  logic [15:0]     hi_q, hi_d;
  logic [15:0]     lo_q, lo_d;

  logic       wr_en;
  logic [1:0] wr_idx;

  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       run_last_q;
  logic [6:0] char_sel;

  function automatic logic [3:0] tail_len(input u2j_pkg::tail_e t);
    logic [3:0] r;
    case (t)
      u2j_pkg::TAIL_CHAR: r = u2j_pkg::TailLenChar;
      u2j_pkg::TAIL_ESC:  r = u2j_pkg::TailLenEsc;
      u2j_pkg::TAIL_U4:   r = u2j_pkg::TailLenU4;
      u2j_pkg::TAIL_PAIR: r = u2j_pkg::TailLenPair;
      default:            r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] u4_char(input logic [15:0] v, input logic [2:0] idx);
    logic [6:0] r;
    case (idx)
      3'd0:    r = u2j_pkg::CharBslash;
      3'd1:    r = u2j_pkg::CharU;
      3'd2:    r = u2j_pkg::hex_char(v[15:12]);
      3'd3:    r = u2j_pkg::hex_char(v[11:8]);
      3'd4:    r = u2j_pkg::hex_char(v[7:4]);
      default: r = u2j_pkg::hex_char(v[3:0]);
    endcase
    return r;
  endfunction

  // plan and buffer update for the incoming word
  always_comb begin
    logic [1:0]     pc_v;
    logic [2:0]     el_v;
    logic           use_begin;
    logic           is_cont;
    logic           grow;
    logic [2:0]     bb_el;
    logic           bb_lead;
    u2j_pkg::tail_e bb_tail;
    logic [6:0]     bb_char;
    logic [15:0]    bb_val;
    logic [20:0]    cp2, cp3, cp4, cp, v;
    logic           ok;

    pc_v = string_start_i ? 2'd0 : pcnt_q;
    el_v = string_start_i ? 3'd0 : elen_q;

    open_d  = string_start_i;
    close_d = string_end_i;
    pre_d   = 2'd0;
    post_d  = 2'd0;
    tail_d  = u2j_pkg::TAIL_NONE;
    tchar_d = 7'h00;
    hi_d    = 16'h0000;
    lo_d    = 16'h0000;
    pcnt_d  = pc_v;
    elen_d  = el_v;
    wr_en   = 1'b0;
    wr_idx  = 2'd0;

    // byte seen with nothing buffered
    bb_lead = 1'b0;
    bb_el   = 3'd0;
    bb_tail = u2j_pkg::TAIL_U4;
    bb_char = data_byte_i[6:0];
    bb_val  = u2j_pkg::CodeRepl;
    if (!data_byte_i[7]) begin
      bb_val  = {8'h00, data_byte_i};
      bb_tail = u2j_pkg::TAIL_ESC;
      case (data_byte_i)
        8'h22:   bb_char = 7'h22;
        8'h5c:   bb_char = 7'h5c;
        8'h08:   bb_char = 7'h62;
        8'h0c:   bb_char = 7'h66;
        8'h0a:   bb_char = 7'h6e;
        8'h0d:   bb_char = 7'h72;
        8'h09:   bb_char = 7'h74;
        default: begin
          if (data_byte_i >= 8'h20 && data_byte_i <= 8'h7e) begin
            bb_tail = u2j_pkg::TAIL_CHAR;
          end else begin
            bb_tail = u2j_pkg::TAIL_U4;
          end
        end
      endcase
    end else if (data_byte_i[7:5] == 3'b110) begin
      bb_lead = 1'b1;
      bb_el   = 3'd2;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      bb_lead = 1'b1;
      bb_el   = 3'd3;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      bb_lead = 1'b1;
      bb_el   = 3'd4;
    end
    if (bb_lead) begin
      bb_tail = u2j_pkg::TAIL_NONE;
    end

    // code point of a completed sequence
    cp2 = {10'd0, pend_q[0][4:0], data_byte_i[5:0]};
    cp3 = {5'd0, pend_q[0][3:0], pend_q[1][5:0], data_byte_i[5:0]};
    cp4 = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], data_byte_i[5:0]};
    is_cont = (data_byte_i[7:6] == 2'b10);
    case (el_v)
      3'd2:    begin
        cp = cp2;
        ok = cp2 >= 21'h80;
      end
      3'd3:    begin
        cp = cp3;
        ok = cp3 >= 21'h800 && !(cp3 >= 21'hd800 && cp3 <= 21'hdfff);
      end
      default: begin
        cp = cp4;
        ok = cp4 >= 21'h10000 && cp4 <= 21'h10ffff;
      end
    endcase
    ok = ok && is_cont;
    v  = cp - 21'h10000;

    use_begin = (pc_v == 2'd0) || (el_v < 3'd2) || (el_v > 3'd4);
    grow      = is_cont && (({1'b0, pc_v} + 3'd1) < el_v);

    if (has_byte_i) begin
      if (use_begin || (!grow && !ok)) begin
        // fresh byte, or an invalid sequence followed by a re-scan
        if (!use_begin) begin
          pre_d = pc_v;
        end
        tail_d  = bb_tail;
        tchar_d = bb_char;
        hi_d    = bb_val;
        if (bb_lead) begin
          wr_en  = 1'b1;
          wr_idx = 2'd0;
          pcnt_d = 2'd1;
          elen_d = bb_el;
        end else begin
          pcnt_d = 2'd0;
          elen_d = 3'd0;
        end
      end else if (grow) begin
        wr_en  = 1'b1;
        wr_idx = pc_v;
        pcnt_d = pc_v + 2'd1;
      end else begin
        pcnt_d = 2'd0;
        elen_d = 3'd0;
        if (cp[20:16] == 5'd0) begin
          tail_d = u2j_pkg::TAIL_U4;
          hi_d   = cp[15:0];
        end else begin
          tail_d = u2j_pkg::TAIL_PAIR;
          hi_d   = {6'b110110, v[19:10]};
          lo_d   = {6'b110111, v[9:0]};
        end
      end
    end

    if (string_end_i) begin
      post_d = pcnt_d;
      pcnt_d = 2'd0;
      elen_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      elen_q <= 3'd0;
    end else if (cmd_i.load) begin
      pcnt_q <= pcnt_d;
      elen_q <= elen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (wr_en) begin
        pend_q[wr_idx] <= data_byte_i;
      end
      open_q  <= open_d;
      pre_q   <= pre_d;
      post_q  <= post_d;
      close_q <= close_d;
      tail_q  <= tail_d;
      tchar_q <= tchar_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

  // character of the current position
  always_comb begin
    logic [3:0] pm6;
    pm6      = cmd_i.pos - 4'd6;
    char_sel = u2j_pkg::CharQuote;
    unique case (cmd_i.phase) inside
      u2j_pkg::PH_PRE, u2j_pkg::PH_POST: begin
        char_sel = u4_char(u2j_pkg::CodeRepl, cmd_i.pos[2:0]);
      end
      u2j_pkg::PH_TAIL: begin
        case (tail_q)
          u2j_pkg::TAIL_CHAR: char_sel = tchar_q;
          u2j_pkg::TAIL_ESC:
            char_sel = (cmd_i.pos == 4'd0) ? u2j_pkg::CharBslash : tchar_q;
          u2j_pkg::TAIL_PAIR: begin
            if (cmd_i.pos < 4'd6) begin
              char_sel = u4_char(hi_q, cmd_i.pos[2:0]);
            end else begin
              char_sel = u4_char(lo_q, pm6[2:0]);
            end
          end
          default:            char_sel = u4_char(hi_q, cmd_i.pos[2:0]);
        endcase
      end
      default: char_sel = u2j_pkg::CharQuote;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= char_sel;
      run_last_q <= cmd_i.last;
    end
  end

  always_comb begin
    status_o.nxt.open     = open_d;
    status_o.nxt.pre_cnt  = pre_d;
    status_o.nxt.tail_len = tail_len(tail_d);
    status_o.nxt.post_cnt = post_d;
    status_o.nxt.close    = close_d;
    status_o.cur.open     = open_q;
    status_o.cur.pre_cnt  = pre_q;
    status_o.cur.tail_len = tail_len(tail_q);
    status_o.cur.post_cnt = post_q;
    status_o.cur.close    = close_q;
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

endmodule

// ----- sv/u2j_ctrl.sv -----
// ----------------------------------------------------------------------------
// u2j_ctrl
// Controller: walks the phases of one word's output, one character a cycle while the output has room.
// ----------------------------------------------------------------------------
module u2j_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u2j_pkg::u2j_status_t status_i,
  output u2j_pkg::u2j_cmd_t    cmd_o
);

  u2j_pkg::phase_e state_q, state_d;
  logic [3:0]      pos_q, pos_d;
  logic [1:0]      rep_q, rep_d;

  function automatic u2j_pkg::phase_e from_post(input u2j_pkg::plan_info_t i);
    u2j_pkg::phase_e r;
    if (i.post_cnt != 2'd0) begin
      r = u2j_pkg::PH_POST;
    end else if (i.close) begin
      r = u2j_pkg::PH_CLOSE;
    end else begin
      r = u2j_pkg::PH_IDLE;
    end
    return r;
  endfunction

  function automatic u2j_pkg::phase_e from_tail(input u2j_pkg::plan_info_t i);
    return (i.tail_len != 4'd0) ? u2j_pkg::PH_TAIL : from_post(i);
  endfunction

  function automatic u2j_pkg::phase_e from_pre(input u2j_pkg::plan_info_t i);
    return (i.pre_cnt != 2'd0) ? u2j_pkg::PH_PRE : from_tail(i);
  endfunction

  function automatic u2j_pkg::phase_e next_of(input u2j_pkg::phase_e ph,
                                              input u2j_pkg::plan_info_t i);
    u2j_pkg::phase_e r;
    unique case (ph)
      u2j_pkg::PH_OPEN: r = from_pre(i);
      u2j_pkg::PH_PRE:  r = from_tail(i);
      u2j_pkg::PH_TAIL: r = from_post(i);
      u2j_pkg::PH_POST: r = i.close ? u2j_pkg::PH_CLOSE : u2j_pkg::PH_IDLE;
      default:          r = u2j_pkg::PH_IDLE;
    endcase
    return r;
  endfunction

  always_comb begin
    logic            accept;
    logic            emit;
    logic            done;
    logic            wrap;
    u2j_pkg::phase_e nxt;
    u2j_pkg::phase_e first;

    accept = in_valid_i && (state_q == u2j_pkg::PH_IDLE);
    emit   = (state_q != u2j_pkg::PH_IDLE) && status_i.out_free;
    wrap   = (pos_q == u2j_pkg::U4LastPos);

    unique case (state_q) inside
      u2j_pkg::PH_PRE, u2j_pkg::PH_POST: done = wrap && (rep_q == 2'd1);
      u2j_pkg::PH_TAIL: done = (pos_q == status_i.cur.tail_len - 4'd1);
      default:          done = 1'b1;
    endcase

    nxt   = next_of(state_q, status_i.cur);
    first = status_i.nxt.open ? u2j_pkg::PH_OPEN : from_pre(status_i.nxt);

    state_d = state_q;
    pos_d   = pos_q;
    rep_d   = rep_q;
    if (accept) begin
      state_d = first;
      pos_d   = 4'd0;
      rep_d   = (first == u2j_pkg::PH_PRE) ? status_i.nxt.pre_cnt
                                           : status_i.nxt.post_cnt;
    end else if (emit) begin
      if (done) begin
        state_d = nxt;
        pos_d   = 4'd0;
        rep_d   = (nxt == u2j_pkg::PH_PRE) ? status_i.cur.pre_cnt
                                         : status_i.cur.post_cnt;
      end else if (wrap && (state_q == u2j_pkg::PH_PRE || state_q == u2j_pkg::PH_POST)) begin
        // next replacement escape
        pos_d = 4'd0;
        rep_d = rep_q - 2'd1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end

    in_ready_o  = (state_q == u2j_pkg::PH_IDLE);
    cmd_o.load  = accept;
    cmd_o.emit  = emit;
    cmd_o.last  = done && (nxt == u2j_pkg::PH_IDLE);
    cmd_o.phase = state_q;
    cmd_o.pos   = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u2j_pkg::PH_IDLE;
      pos_q   <= 4'd0;
      rep_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// ----- sv/utf8_to_json_ascii_escaper_core.sv -----
// First character: written into the output register once the controller has left idle and the output has room.
// Throughput: one character per cycle from the phase sequencer in u2j_ctrl while the output is not stalled;
// the input is not ready for a new word until every character of the current word has been emitted.
// A word that yields no character frees the input the next cycle.
// Reset (asynchronous, active low) clears the sequencer, the buffered byte count and output valid.
// ----------------------------------------------------------------------------
// utf8_to_json_ascii_escaper_core
// Escapes a utf-8 string, one byte per word, into ascii-only json characters.
// ----------------------------------------------------------------------------
module utf8_to_json_ascii_escaper_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  u2j_in_if.sink    in_i,
  u2j_out_if.source out_o
);

  u2j_pkg::u2j_cmd_t    cmd;
  u2j_pkg::u2j_status_t status;

  u2j_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  u2j_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (in_i.data_byte),
    .has_byte_i     (in_i.has_byte),
    .string_start_i (in_i.string_start),
    .string_end_i   (in_i.string_end),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_char_o     (out_o.out_char),
    .run_last_o     (out_o.run_last)
  );

endmodule

// ----- verif/utf8_to_json_ascii_escaper_core_test.sv -----
// ----------------------------------------------------------------------------
// utf8_to_json_ascii_escaper_core_test
// Self-checking bench of the json string escaper. Feeds directed and random
// utf-8 strings one byte per word, works out every escaped character of each
// word in its own escaper model and compares the output stream in order.
// ----------------------------------------------------------------------------
module utf8_to_json_ascii_escaper_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       string_start;
    logic       string_end;
  } str_word_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_last;
  } esc_char_t;

  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WordsPerPhase = 58;
  localparam int unsigned PhaseCount    = 4;

  localparam logic [6:0] CharB = 7'h62;
  localparam logic [6:0] CharF = 7'h66;
  localparam logic [6:0] CharN = 7'h6e;
  localparam logic [6:0] CharR = 7'h72;
  localparam logic [6:0] CharT = 7'h74;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  u2j_in_if  in_bus ();
  u2j_out_if out_bus ();

  utf8_to_json_ascii_escaper_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  str_word_t drv_word  = '0;
  logic      drv_valid = 1'b0;
  logic      snk_ready = 1'b0;

  assign in_bus.valid        = drv_valid;
  assign in_bus.data_byte    = drv_word.data_byte;
  assign in_bus.has_byte     = drv_word.has_byte;
  assign in_bus.string_start = drv_word.string_start;
  assign in_bus.string_end   = drv_word.string_end;
  assign out_bus.ready       = snk_ready;

  str_word_t   word_q [$];
  esc_char_t   expected_chars [$];
  logic [7:0]  body_q [$];
  int unsigned words_made    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  logic        hold_arm      = 1'b0;
  logic        hold_taken    = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned err_cnt       = 0;
  int unsigned quiet_cycles  = 0;

  // escaper model state
  logic [7:0]  held_byte [3];
  int unsigned held_cnt = 0;
  int unsigned seq_len  = 0;
  logic [6:0]  char_run [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void run_add(input logic [6:0] c);
    char_run.insert(char_run.size(), c);
  endfunction

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    return (n > 4'd9) ? 7'h61 + 7'(n - 4'd10) : 7'h30 + 7'(n);
  endfunction

  function automatic void push_u_escape(input logic [15:0] v);
    run_add(u2j_pkg::CharBslash);
    run_add(u2j_pkg::CharU);
    for (int i = 3; i >= 0; i--) run_add(nibble_char(v[i*4 +: 4]));
  endfunction

  function automatic void push_plain(input logic [6:0] c);
    logic [6:0] short_c;
    case (c)
      7'h22:   short_c = u2j_pkg::CharQuote;
      7'h5c:   short_c = u2j_pkg::CharBslash;
      7'h08:   short_c = CharB;
      7'h0c:   short_c = CharF;
      7'h0a:   short_c = CharN;
      7'h0d:   short_c = CharR;
      7'h09:   short_c = CharT;
      default: short_c = 7'h00;
    endcase
    if (short_c != 7'h00) begin
      run_add(u2j_pkg::CharBslash);
      run_add(short_c);
    end else if (c >= 7'h20 && c <= 7'h7e) begin
      run_add(c);
    end else begin
      push_u_escape({9'h000, c});
    end
  endfunction

  function automatic void take_lead_byte(input logic [7:0] b);
    if (!b[7]) begin
      push_plain(b[6:0]);
      return;
    end
    if (b[7:5] == 3'b110) seq_len = 2;
    else if (b[7:4] == 4'b1110) seq_len = 3;
    else if (b[7:3] == 5'b11110) seq_len = 4;
    else begin
      push_u_escape(u2j_pkg::CodeRepl);
      return;
    end
    held_byte[0] = b;
    held_cnt = 1;
  endfunction

  function automatic void push_code_point(input logic [20:0] cp);
    logic [20:0] v;
    if (cp <= 21'h00ffff) begin
      push_u_escape(cp[15:0]);
    end else begin
      v = cp - 21'h010000;
      push_u_escape(16'hd800 + {6'h00, v[19:10]});
      push_u_escape(16'hdc00 + {6'h00, v[9:0]});
    end
  endfunction

  function automatic void take_cont_byte(input logic [7:0] b);
    logic [7:0]  seq [4];
    int unsigned n;
    logic        good;
    logic [20:0] cp;
    n = (held_cnt > 3) ? 3 : held_cnt;
    for (int i = 0; i < n; i++) seq[i] = held_byte[i];
    seq[n] = b;
    good = 1'b0;
    cp = '0;
    if (b[7:6] == 2'b10) begin
      if (n + 1 < seq_len) begin
        held_byte[n] = b;
        held_cnt = n + 1;
        return;
      end
      case (seq_len)
        2: begin
          cp = {10'h000, seq[0][4:0], seq[1][5:0]};
          good = cp >= 21'h80;
        end
        3: begin
          cp = {5'h00, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
          good = cp >= 21'h800 && !(cp >= 21'hd800 && cp <= 21'hdfff);
        end
        default: begin
          cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
          good = cp >= 21'h10000 && cp <= 21'h10ffff;
        end
      endcase
    end
    held_cnt = 0;
    seq_len = 0;
    if (good) begin
      push_code_point(cp);
    end else begin
      // replacement for the lead, then every later byte is looked at afresh
      push_u_escape(u2j_pkg::CodeRepl);
      for (int i = 1; i <= n; i++) take_lead_byte(seq[i]);
    end
  endfunction

  function automatic void escape_word(input str_word_t w);
    esc_char_t e;
    char_run.delete();
    if (w.string_start) begin
      held_cnt = 0;
      seq_len = 0;
      run_add(u2j_pkg::CharQuote);
    end
    if (w.has_byte) begin
      if (held_cnt == 0 || seq_len < 2 || seq_len > 4) take_lead_byte(w.data_byte);
      else take_cont_byte(w.data_byte);
    end
    if (w.string_end) begin
      repeat (held_cnt) push_u_escape(u2j_pkg::CodeRepl);
      held_cnt = 0;
      seq_len = 0;
      run_add(u2j_pkg::CharQuote);
    end
    foreach (char_run[k]) begin
      e.ch      = char_run[k];
      e.is_last = (k == char_run.size() - 1);
      expected_chars.insert(expected_chars.size(), e);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void body_add(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  function automatic void add_word(input logic [7:0] b, input logic has,
                                   input logic is_start, input logic is_end);
    str_word_t w;
    w.data_byte    = b;
    w.has_byte     = has;
    w.string_start = is_start;
    w.string_end   = is_end;
    word_q.insert(word_q.size(), w);
    words_made++;
  endfunction

  function automatic void encode_cp(input logic [20:0] cp, input int unsigned len);
    case (len)
      2: begin
        body_add({3'b110, cp[10:6]});
        body_add({2'b10, cp[5:0]});
      end
      3: begin
        body_add({4'b1110, cp[15:12]});
        body_add({2'b10, cp[11:6]});
        body_add({2'b10, cp[5:0]});
      end
      default: begin
        body_add({5'b11110, cp[20:18]});
        body_add({2'b10, cp[17:12]});
        body_add({2'b10, cp[11:6]});
        body_add({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_segment();
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    logic [20:0] cp;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2, 3: body_add(8'($urandom_range(0, 127)));
      4: encode_cp(21'($urandom_range(32'h80, 32'h7ff)), 2);
      5: encode_cp(21'($urandom_range(32'h800, 32'hffff)), 3);
      6: encode_cp(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
      7: body_add(8'($urandom_range(8'h80, 8'hff)));
      8: begin
        // edges and ill-formed encodings
        case ($urandom_range(0, 7))
          0: encode_cp(21'($urandom_range(0, 32'h7f)), 2);
          1: encode_cp(21'($urandom_range(0, 32'h7ff)), 3);
          2: encode_cp(21'($urandom_range(0, 32'hffff)), 4);
          3: encode_cp(21'($urandom_range(32'hd800, 32'hdfff)), 3);
          4: encode_cp(21'($urandom_range(32'h110000, 32'h1fffff)), 4);
          5: encode_cp($urandom_range(0, 1) ? 21'h80 : 21'h7ff, 2);
          6: begin
            case ($urandom_range(0, 3))
              0: cp = 21'h800;
              1: cp = 21'hd7ff;
              2: cp = 21'he000;
              default: cp = 21'hffff;
            endcase
            encode_cp(cp, 3);
          end
          default: encode_cp($urandom_range(0, 1) ? 21'h10000 : 21'h10ffff, 4);
        endcase
      end
      9, 10: begin
        // cut short or corrupted sequence
        len = $urandom_range(2, 4);
        base = body_q.size();
        case (len)
          2: cp = 21'($urandom_range(32'h80, 32'h7ff));
          3: cp = 21'($urandom_range(32'h800, 32'hffff));
          default: cp = 21'($urandom_range(32'h10000, 32'h10ffff));
        endcase
        encode_cp(cp, len);
        if ($urandom_range(0, 1)) void'(body_q.pop_back());
        else body_q[base + $urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end
      default: repeat ($urandom_range(1, 3)) body_add(8'($urandom_range(8'h80, 8'hbf)));
    endcase
  endfunction

  function automatic void add_string();
    logic sep_start;
    logic sep_end;
    int unsigned n;
    body_q.delete();
    repeat ($urandom_range(0, 6)) add_segment();
    n = body_q.size();
    if (n == 0) begin
      if ($urandom_range(0, 1)) begin
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
      end else begin
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
      end
      return;
    end
    sep_start = 1'($urandom_range(0, 1));
    sep_end   = 1'($urandom_range(0, 1));
    if (sep_start) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
    foreach (body_q[i]) begin
      add_word(body_q[i], 1'b1, (i == 0) && !sep_start, (i == n - 1) && !sep_end);
    end
    if (sep_end) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 4)) begin
      add_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (word_q.size() != 0 || drv_valid || expected_chars.size() != 0);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_word  <= '0;
    end else begin
      if (drv_valid && in_bus.ready) escape_word(drv_word);
      if (!drv_valid || in_bus.ready) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          drv_word  <= word_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : out_side
    esc_char_t want;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_bus.valid && snk_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("character with none expected", {1'b0, out_bus.out_char}, 8'h00);
        end else begin
          want = expected_chars.pop_front();
          if (out_bus.out_char !== want.ch)
            report_mismatch("out_char", {1'b0, out_bus.out_char}, {1'b0, want.ch});
          if (out_bus.run_last !== want.is_last)
            report_mismatch("run_last", {7'h00, out_bus.run_last}, {7'h00, want.is_last});
        end
      end
      // one long hold-off so the core backs up into its input
      if (hold_arm && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && in_bus.ready) || (out_bus.valid && snk_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run
    int unsigned phase_goal;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_word(8'h00, 1'b0, 1'b1, 1'b1);   // empty string
    add_word(8'h22, 1'b1, 1'b1, 1'b0);
    add_word(8'h5c, 1'b1, 1'b0, 1'b0);
    add_word(8'h08, 1'b1, 1'b0, 1'b0);
    add_word(8'h0c, 1'b1, 1'b0, 1'b0);
    add_word(8'h0a, 1'b1, 1'b0, 1'b0);
    add_word(8'h0d, 1'b1, 1'b0, 1'b0);
    add_word(8'h09, 1'b1, 1'b0, 1'b0);
    add_word(8'h00, 1'b1, 1'b0, 1'b0);
    add_word(8'h7f, 1'b1, 1'b0, 1'b0);
    add_word(8'h7e, 1'b1, 1'b0, 1'b0);
    // highest code point, comes out as a surrogate pair
    add_word(8'hf4, 1'b1, 1'b0, 1'b0);
    add_word(8'h8f, 1'b1, 1'b0, 1'b0);
    add_word(8'hbf, 1'b1, 1'b0, 1'b0);
    add_word(8'hbf, 1'b1, 1'b0, 1'b0);
    // overlong, then the continuation is seen again as a stray byte
    add_word(8'hc0, 1'b1, 1'b0, 1'b0);
    add_word(8'h80, 1'b1, 1'b0, 1'b0);
    // encoded surrogate
    add_word(8'hed, 1'b1, 1'b0, 1'b0);
    add_word(8'ha0, 1'b1, 1'b0, 1'b0);
    add_word(8'h80, 1'b1, 1'b0, 1'b0);
    // above the unicode range
    add_word(8'hf4, 1'b1, 1'b0, 1'b0);
    add_word(8'h90, 1'b1, 1'b0, 1'b0);
    add_word(8'h80, 1'b1, 1'b0, 1'b0);
    add_word(8'h80, 1'b1, 1'b0, 1'b0);
    add_word(8'hff, 1'b1, 1'b0, 1'b0);  // bad lead
    add_word(8'he2, 1'b1, 1'b0, 1'b0);  // lead broken by plain ascii
    add_word(8'h41, 1'b1, 1'b0, 1'b0);
    add_word(8'h55, 1'b0, 1'b0, 1'b0);  // word that yields nothing
    add_word(8'hf0, 1'b1, 1'b0, 1'b0);  // cut off by the end mark
    add_word(8'h9f, 1'b1, 1'b0, 1'b1);
    add_word(8'he2, 1'b1, 1'b1, 1'b0);  // buffered lead dropped by a new start
    add_word(8'h41, 1'b1, 1'b1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 36; snk_stall_pct = 36; end
      endcase
      phase_goal = words_made + WordsPerPhase;
      while (words_made < phase_goal) begin
        if ($urandom_range(0, 6) == 0) add_noise();
        else add_string();
      end
      if (ph == 0) hold_arm = 1'b1;
      // sender stays quiet until the whole phase has come out
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
